/* rtl/mpfe_pkg.sv */
// ----------------------------------------------------------------------------
// mpfe_pkg
// Shared types and codes of the page-organised monochrome frame store:
// item structs, action codes, controller states and control/status bundles.
// ----------------------------------------------------------------------------
package mpfe_pkg;

  // action codes carried by an input item
  typedef enum logic [2:0] {
    ACT_DRAW      = 3'd0,
    ACT_READ_PIX  = 3'd1,
    ACT_TOGGLE    = 3'd2,
    ACT_FILL      = 3'd3,
    ACT_INVERT    = 3'd4,
    ACT_CLEAR     = 3'd5,
    ACT_READ_BYTE = 3'd6
  } action_e;

  // result kind codes
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_BYTE  = 1'b1;

  // width of a row group index taken from an 8-bit row
  localparam int unsigned GRP_W = 5;

  // input item
  typedef struct packed {
    logic [2:0] action;
    logic [7:0] pixel_x;
    logic [7:0] pixel_y;
    logic [7:0] x_end;
    logic [7:0] y_end;
    logic       pixel_value;
    logic [2:0] page_index;
  } in_item_t;

  // result item
  typedef struct packed {
    logic       result_kind;
    logic       pixel_bit;
    logic [7:0] frame_byte;
  } out_item_t;

  // controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PIXEL,
    ST_RECT_RD,
    ST_RECT_WR
  } state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic pix_load;
    logic rect_load;
    logic clr_load;
    logic pix_done;
    logic rect_rd;
    logic rect_wr;
    logic clr_wr;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic rect_empty;
    logic rect_last;
    logic clr_last;
    logic needs_out;
    logic out_free;
  } stat_t;

endpackage

/* rtl/mpfe_ctrl.sv */
// ----------------------------------------------------------------------------
// mpfe_ctrl
// Sequencer of the frame store: accepts items, steps pixel read-modify-write,
// rectangle byte walks and the clearing sweep.
// ----------------------------------------------------------------------------
module mpfe_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic [2:0]     action_i,
  output logic           in_ready_o,
  input  mpfe_pkg::stat_t stat_i,
  output mpfe_pkg::cmd_t  cmd_o
);

  mpfe_pkg::state_e state_q, state_d;

  // state register, reset starts the clearing sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mpfe_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      mpfe_pkg::ST_CLEAR: begin
        if (stat_i.clr_last) state_d = mpfe_pkg::ST_IDLE;
      end
      mpfe_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          case (action_i)
            mpfe_pkg::ACT_DRAW, mpfe_pkg::ACT_READ_PIX, mpfe_pkg::ACT_TOGGLE,
            mpfe_pkg::ACT_READ_BYTE: state_d = mpfe_pkg::ST_PIXEL;
            mpfe_pkg::ACT_FILL, mpfe_pkg::ACT_INVERT: begin
              if (!stat_i.rect_empty) state_d = mpfe_pkg::ST_RECT_RD;
            end
            mpfe_pkg::ACT_CLEAR: state_d = mpfe_pkg::ST_CLEAR;
            default: state_d = mpfe_pkg::ST_IDLE;
          endcase
        end
      end
      mpfe_pkg::ST_PIXEL: begin
        if (!stat_i.needs_out || stat_i.out_free) state_d = mpfe_pkg::ST_IDLE;
      end
      mpfe_pkg::ST_RECT_RD: state_d = mpfe_pkg::ST_RECT_WR;
      mpfe_pkg::ST_RECT_WR: begin
        state_d = stat_i.rect_last ? mpfe_pkg::ST_IDLE : mpfe_pkg::ST_RECT_RD;
      end
      default: state_d = mpfe_pkg::ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      mpfe_pkg::ST_CLEAR: cmd_o.clr_wr = 1'b1;
      mpfe_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (action_i)
            mpfe_pkg::ACT_DRAW, mpfe_pkg::ACT_READ_PIX, mpfe_pkg::ACT_TOGGLE,
            mpfe_pkg::ACT_READ_BYTE: cmd_o.pix_load = 1'b1;
            mpfe_pkg::ACT_FILL, mpfe_pkg::ACT_INVERT: cmd_o.rect_load = 1'b1;
            mpfe_pkg::ACT_CLEAR: cmd_o.clr_load = 1'b1;
            default: cmd_o = '0;
          endcase
        end
      end
      mpfe_pkg::ST_PIXEL: begin
        cmd_o.pix_done = !stat_i.needs_out || stat_i.out_free;
      end
      mpfe_pkg::ST_RECT_RD: cmd_o.rect_rd = 1'b1;
      mpfe_pkg::ST_RECT_WR: cmd_o.rect_wr = 1'b1;
      default: cmd_o = '0;
    endcase
  end

endmodule

/* rtl/mpfe_datapath.sv */
// ----------------------------------------------------------------------------
// mpfe_datapath
// Frame byte memory with read-modify-write path, rectangle walker, clearing
// counter and the result register.
// ----------------------------------------------------------------------------
module mpfe_datapath #(
  parameter int unsigned WIDTH_PIXELS  = 128,
  parameter int unsigned HEIGHT_PIXELS = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mpfe_pkg::in_item_t  in_item_i,
  input  mpfe_pkg::cmd_t      cmd_i,
  output mpfe_pkg::stat_t     stat_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output mpfe_pkg::out_item_t out_item_o
);

  localparam int unsigned PAGES = (HEIGHT_PIXELS + 7) / 8;
  localparam int unsigned DEPTH = PAGES * WIDTH_PIXELS;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = AW + 6;
  localparam int unsigned GW    = mpfe_pkg::GRP_W;

  // byte address of a page and column
  function automatic logic [AW-1:0] byte_addr(input logic [GW-1:0] page,
                                              input logic [7:0] col);
    logic [CW-1:0] sum;
    sum = CW'(page) * CW'(WIDTH_PIXELS) + CW'(col);
    return sum[AW-1:0];
  endfunction

  logic [7:0]    mem [DEPTH];
  logic [7:0]    rdata_q;
  logic [AW-1:0] rd_addr, wr_addr, addr_q;
  logic [7:0]    wr_data;
  logic          rd_en, wr_en;

  logic [2:0]    act_q;
  logic          val_q, xor_q, inr_q;
  logic [7:0]    mask_q;

  logic [7:0]    cx_q, x1_q, y0_q, y1_q;
  logic [GW-1:0] grp_q;
  logic [AW-1:0] clr_q;

  logic          out_valid_q;
  mpfe_pkg::out_item_t out_item_q;

  // input decode
  logic [7:0]    x1c, y1c;
  logic          pix_inr, byte_inr;
  logic [GW-1:0] pix_page;
  logic [AW-1:0] load_addr;
  logic [7:0]    load_mask;

  always_comb begin
    x1c = (in_item_i.x_end > 8'(WIDTH_PIXELS - 1)) ? 8'(WIDTH_PIXELS - 1)
                                                    : in_item_i.x_end;
    y1c = (in_item_i.y_end > 8'(HEIGHT_PIXELS - 1)) ? 8'(HEIGHT_PIXELS - 1)
                                                     : in_item_i.y_end;
    pix_inr  = ({1'b0, in_item_i.pixel_x} < 9'(WIDTH_PIXELS)) &&
               ({1'b0, in_item_i.pixel_y} < 9'(HEIGHT_PIXELS));
    byte_inr = ({1'b0, in_item_i.pixel_x} < 9'(WIDTH_PIXELS)) &&
               (GW'(in_item_i.page_index) < GW'(PAGES));
    pix_page = GW'(PAGES - 1) - in_item_i.pixel_y[7:3];
    if (in_item_i.action == mpfe_pkg::ACT_READ_BYTE) begin
      load_addr = byte_addr(GW'(in_item_i.page_index), in_item_i.pixel_x);
    end else begin
      load_addr = byte_addr(pix_page, in_item_i.pixel_x);
    end
    load_mask = 8'h80 >> in_item_i.pixel_y[2:0];
  end

  // rectangle walker byte address and row mask
  logic [2:0]    lo_bit, hi_bit;
  logic [7:0]    rect_mask;
  logic [AW-1:0] rect_addr;

  always_comb begin
    lo_bit    = (grp_q == y0_q[7:3]) ? y0_q[2:0] : 3'd0;
    hi_bit    = (grp_q == y1_q[7:3]) ? y1_q[2:0] : 3'd7;
    rect_mask = (8'hFF >> lo_bit) & (8'hFF << (3'd7 - hi_bit));
    rect_addr = byte_addr(GW'(PAGES - 1) - grp_q, cx_q);
  end

  // memory port control
  logic pix_wr;
  assign pix_wr = cmd_i.pix_done && inr_q &&
                  (act_q == mpfe_pkg::ACT_DRAW || act_q == mpfe_pkg::ACT_TOGGLE);

  always_comb begin
    rd_en   = cmd_i.pix_load || cmd_i.rect_rd;
    rd_addr = cmd_i.pix_load ? load_addr : rect_addr;
    wr_en   = pix_wr || cmd_i.rect_wr || cmd_i.clr_wr;
    wr_addr = cmd_i.clr_wr ? clr_q : addr_q;
    if (cmd_i.clr_wr) begin
      wr_data = 8'h00;
    end else if (xor_q) begin
      wr_data = rdata_q ^ mask_q;
    end else if (val_q) begin
      wr_data = rdata_q | mask_q;
    end else begin
      wr_data = rdata_q & ~mask_q;
    end
  end

  // frame byte memory
  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rdata_q <= mem[rd_addr];
  end

  // operand registers
  always_ff @(posedge clk_i) begin
    if (rd_en) addr_q <= rd_addr;
    if (cmd_i.pix_load) begin
      act_q  <= in_item_i.action;
      val_q  <= in_item_i.pixel_value;
      xor_q  <= (in_item_i.action == mpfe_pkg::ACT_TOGGLE);
      inr_q  <= (in_item_i.action == mpfe_pkg::ACT_READ_BYTE) ? byte_inr : pix_inr;
      mask_q <= load_mask;
    end else if (cmd_i.rect_load) begin
      act_q  <= in_item_i.action;
      val_q  <= in_item_i.pixel_value;
      xor_q  <= (in_item_i.action == mpfe_pkg::ACT_INVERT);
      cx_q   <= in_item_i.pixel_x;
      x1_q   <= x1c;
      y0_q   <= in_item_i.pixel_y;
      y1_q   <= y1c;
      grp_q  <= in_item_i.pixel_y[7:3];
    end else if (cmd_i.rect_rd) begin
      mask_q <= rect_mask;
    end else if (cmd_i.rect_wr) begin
      // next row group, then next column
      if (grp_q == y1_q[7:3]) begin
        grp_q <= y0_q[7:3];
        cx_q  <= cx_q + 8'd1;
      end else begin
        grp_q <= grp_q + GW'(1);
      end
    end
  end

  // clearing sweep counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr_load) begin
      clr_q <= '0;
    end else if (cmd_i.clr_wr) begin
      clr_q <= clr_q + AW'(1);
    end
  end

  // result register
  logic out_load;
  assign out_load = cmd_i.pix_done && stat_o.needs_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      if (act_q == mpfe_pkg::ACT_READ_BYTE) begin
        out_item_q.result_kind <= mpfe_pkg::KIND_BYTE;
        out_item_q.pixel_bit   <= 1'b0;
        out_item_q.frame_byte  <= inr_q ? rdata_q : 8'h00;
      end else begin
        out_item_q.result_kind <= mpfe_pkg::KIND_PIXEL;
        out_item_q.pixel_bit   <= inr_q && |(rdata_q & mask_q);
        out_item_q.frame_byte  <= 8'h00;
      end
    end
  end

  // status to the controller
  always_comb begin
    stat_o.rect_empty = (in_item_i.pixel_x > x1c) || (in_item_i.pixel_y > y1c);
    stat_o.rect_last  = (grp_q == y1_q[7:3]) && (cx_q == x1_q);
    stat_o.clr_last   = (clr_q == AW'(DEPTH - 1));
    stat_o.needs_out  = (act_q == mpfe_pkg::ACT_READ_PIX) ||
                        (act_q == mpfe_pkg::ACT_READ_BYTE);
    stat_o.out_free   = !out_valid_q || out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

/* rtl/mono_page_framebuffer_engine.sv */
// Pixel draw, read, toggle and byte read: accept with memory read, then one
// modify-write or result load, held while an earlier result waits.
// Rectangle fill/invert: accept, then a read and a write per touched frame
// byte (one memory port pair). Clear: accept, then one byte written per cycle.
// Reset (async, active low) runs the same clearing pass, in_ready_o low until it ends.
// ----------------------------------------------------------------------------
// mono_page_framebuffer_engine
// Monochrome frame store organised as pages of column bytes, with pixel,
// rectangle, clear and byte scan-out actions.
// ----------------------------------------------------------------------------
module mono_page_framebuffer_engine #(
  parameter int unsigned WIDTH_PIXELS  = 128,
  parameter int unsigned HEIGHT_PIXELS = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  mpfe_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output mpfe_pkg::out_item_t out_item_o
);

  mpfe_pkg::cmd_t  cmd;
  mpfe_pkg::stat_t stat;

  // sequencer
  mpfe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .action_i   (in_item_i.action),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // memory and arithmetic
  mpfe_datapath #(
    .WIDTH_PIXELS  (WIDTH_PIXELS),
    .HEIGHT_PIXELS (HEIGHT_PIXELS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

/* rtl/mpfe_checker.sv */
// ----------------------------------------------------------------------------
// mpfe_checker
// Port-level checks of the frame store engine, bound to the top level.
// ----------------------------------------------------------------------------
module mpfe_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input mpfe_pkg::in_item_t  in_item_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input mpfe_pkg::out_item_t out_item_o
);

  // a waiting result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while stalled");

  // byte answers carry no pixel bit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.result_kind == mpfe_pkg::KIND_BYTE |->
      !out_item_o.pixel_bit)
    else $error("byte answer with pixel bit set");

  // pixel answers carry no frame byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.result_kind == mpfe_pkg::KIND_PIXEL |->
      out_item_o.frame_byte == 8'h00)
    else $error("pixel answer with frame byte set");

  // a pixel read occupies the engine for its modify cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_item_i.action == mpfe_pkg::ACT_READ_PIX |=>
      !in_ready_o)
    else $error("item taken during pixel read");

  // nothing taken or shown during reset
  assert property (@(posedge clk_i) !rst_ni |-> !in_ready_o && !out_valid_o)
    else $error("handshake active in reset");

endmodule

bind mono_page_framebuffer_engine mpfe_checker u_mpfe_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);

/* tb/sv/mpfe_frame_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpfe_frame_checker
// Watches both item channels of the frame store, keeps its own copy of the
// page-organised pixel memory, predicts the answer to every read action and
// compares each returned item field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module mpfe_frame_checker
  import mpfe_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  in_item_t    in_item_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  out_item_t   out_item_i,
  output int unsigned errors_o,
  output int unsigned pending_o
);

  localparam int unsigned WIDTH_PX   = 128;
  localparam int unsigned HEIGHT_PX  = 64;
  localparam int unsigned PAGE_COUNT = (HEIGHT_PX + 7) / 8;

  // shadow of the frame store, page major, one byte per column
  logic [7:0]  frame_bytes [PAGE_COUNT*WIDTH_PX];
  out_item_t   answers_q [$];
  out_item_t   oldest_answer;
  int unsigned error_count;
  int unsigned pending_count;

  assign errors_o  = error_count;
  assign pending_o = pending_count;

  // row 0 sits in the top bit of the last page
  function automatic int unsigned byte_index(int unsigned x, int unsigned y);
    return (PAGE_COUNT - 1 - y / 8) * WIDTH_PX + x;
  endfunction

  function automatic logic pixel_get(int unsigned x, int unsigned y);
    if (x >= WIDTH_PX || y >= HEIGHT_PX) return 1'b0;
    return frame_bytes[byte_index(x, y)][7 - (y % 8)];
  endfunction

  function automatic void pixel_put(int unsigned x, int unsigned y, logic v);
    if (x >= WIDTH_PX || y >= HEIGHT_PX) return;
    frame_bytes[byte_index(x, y)][7 - (y % 8)] = v;
  endfunction

  function automatic void store_wipe();
    foreach (frame_bytes[i]) frame_bytes[i] = 8'h00;
  endfunction

  // ends clamp to the screen, a start past its end leaves nothing to do
  function automatic void rect_apply(int unsigned x0, int unsigned y0, int unsigned x1,
                                     int unsigned y1, logic invert, logic v);
    if (x1 > WIDTH_PX - 1) x1 = WIDTH_PX - 1;
    if (y1 > HEIGHT_PX - 1) y1 = HEIGHT_PX - 1;
    for (int unsigned x = x0; x <= x1; x++) begin
      for (int unsigned y = y0; y <= y1; y++) begin
        pixel_put(x, y, invert ? ~pixel_get(x, y) : v);
      end
    end
  endfunction

  // apply one accepted item and queue its answer, if it has one
  function automatic void predict_item(in_item_t item);
    out_item_t   answer;
    int unsigned px;
    int unsigned py;
    int unsigned xe;
    int unsigned ye;
    int unsigned pg;
    answer = '0;
    px = 32'(item.pixel_x);
    py = 32'(item.pixel_y);
    xe = 32'(item.x_end);
    ye = 32'(item.y_end);
    pg = 32'(item.page_index);
    case (action_e'(item.action))
      ACT_DRAW: pixel_put(px, py, item.pixel_value);
      ACT_READ_PIX: begin
        answer.result_kind = KIND_PIXEL;
        answer.pixel_bit   = pixel_get(px, py);
        answers_q.push_back(answer);
      end
      ACT_TOGGLE: pixel_put(px, py, ~pixel_get(px, py));
      ACT_FILL: rect_apply(px, py, xe, ye, 1'b0, item.pixel_value);
      ACT_INVERT: rect_apply(px, py, xe, ye, 1'b1, 1'b0);
      ACT_CLEAR: store_wipe();
      ACT_READ_BYTE: begin
        answer.result_kind = KIND_BYTE;
        if (px < WIDTH_PX && pg < PAGE_COUNT) begin
          answer.frame_byte = frame_bytes[pg * WIDTH_PX + px];
        end
        answers_q.push_back(answer);
      end
      default: ;
    endcase
  endfunction

  // returned items are checked before this edge's input item is predicted
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      store_wipe();
      answers_q.delete();
      error_count   = 0;
      pending_count = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (answers_q.size() == 0) begin
          $error("unexpected result item: result_kind %0d pixel_bit %0d frame_byte 0x%02h",
                 out_item_i.result_kind, out_item_i.pixel_bit, out_item_i.frame_byte);
          error_count++;
        end else begin
          oldest_answer = answers_q.pop_front();
          if (out_item_i.result_kind !== oldest_answer.result_kind) begin
            $error("result_kind: expected %0d, actual %0d",
                   oldest_answer.result_kind, out_item_i.result_kind);
            error_count++;
          end
          if (out_item_i.pixel_bit !== oldest_answer.pixel_bit) begin
            $error("pixel_bit: expected %0d, actual %0d",
                   oldest_answer.pixel_bit, out_item_i.pixel_bit);
            error_count++;
          end
          if (out_item_i.frame_byte !== oldest_answer.frame_byte) begin
            $error("frame_byte: expected 0x%02h, actual 0x%02h",
                   oldest_answer.frame_byte, out_item_i.frame_byte);
            error_count++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        predict_item(in_item_i);
      end
      pending_count = answers_q.size();
    end
  end

endmodule

/* tb/sv/tb_mono_page_framebuffer_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mono_page_framebuffer_engine
// Drives pixel, rectangle, clear and byte read actions into the frame store
// with random idle on both channels, first a directed set of corner cases and
// then random items, many aimed at recently drawn spots. A checker beside the
// block predicts and compares every answer; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_mono_page_framebuffer_engine;
  import mpfe_pkg::*;

  localparam logic [2:0]  ACT_UNUSED    = 3'd7;
  localparam int unsigned RANDOM_ITEMS  = 1250;
  localparam int unsigned SETTLE_CYCLES = 2500;
  localparam int unsigned CYCLE_LIMIT   = 1_500_000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_item;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_item;
  int unsigned errors;
  int unsigned pending;

  mono_page_framebuffer_engine uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item)
  );

  mpfe_frame_checker u_checker (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_i (in_ready),
    .in_item_i  (in_item),
    .out_valid_i(out_valid),
    .out_ready_i(out_ready),
    .out_item_i (out_item),
    .errors_o   (errors),
    .pending_o  (pending)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("tb_mono_page_framebuffer_engine: errors");
    $finish;
  end

  // receiver stalls, mostly short, a few long, some long open stretches
  initial begin
    int unsigned roll;
    int unsigned hold;
    logic        level;
    out_ready = 1'b0;
    @(posedge rst_n);
    @(posedge clk);
    forever begin
      roll = $urandom_range(0, 99);
      if (roll < 60) begin
        level = 1'b1;
        hold  = $urandom_range(1, 8);
      end else if (roll < 88) begin
        level = 1'b0;
        hold  = $urandom_range(1, 3);
      end else if (roll < 96) begin
        level = 1'b0;
        hold  = $urandom_range(4, 40);
      end else begin
        level = 1'b1;
        hold  = $urandom_range(50, 200);
      end
      out_ready <= level;
      repeat (hold) @(posedge clk);
    end
  end

  function automatic in_item_t make_item(logic [2:0] action, logic [7:0] x, logic [7:0] y,
                                         logic [7:0] xe, logic [7:0] ye, logic v,
                                         logic [2:0] page);
    in_item_t item;
    item.action      = action;
    item.pixel_x     = x;
    item.pixel_y     = y;
    item.x_end       = xe;
    item.y_end       = ye;
    item.pixel_value = v;
    item.page_index  = page;
    return item;
  endfunction

  // random idle first, then hold the item until it is taken
  task automatic send_item(input in_item_t item);
    int unsigned roll;
    int unsigned gap;
    roll = $urandom_range(0, 99);
    if (roll < 55) gap = 0;
    else if (roll < 85) gap = $urandom_range(1, 3);
    else if (roll < 97) gap = $urandom_range(4, 12);
    else gap = $urandom_range(20, 60);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= item;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
  endtask

  // hold off until every predicted answer has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  // stimulus
  initial begin
    in_item_t    item;
    int unsigned sent;
    int unsigned roll;
    int unsigned pick;
    logic [7:0]  spot_x [$];
    logic [7:0]  spot_y [$];

    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_item  = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // corners of the screen and the byte layout
    send_item(make_item(ACT_READ_BYTE, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 3'd7));
    send_item(make_item(ACT_DRAW, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 3'd0));
    send_item(make_item(ACT_READ_PIX, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 3'd0));
    send_item(make_item(ACT_READ_BYTE, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 3'd7));
    send_item(make_item(ACT_DRAW, 8'd127, 8'd63, 8'd255, 8'd255, 1'b1, 3'd7));
    send_item(make_item(ACT_READ_PIX, 8'd127, 8'd63, 8'd0, 8'd0, 1'b0, 3'd0));
    send_item(make_item(ACT_READ_BYTE, 8'd127, 8'd0, 8'd0, 8'd0, 1'b0, 3'd0));
    // pixels off the screen: writes dropped, reads answer dark
    send_item(make_item(ACT_DRAW, 8'd128, 8'd0, 8'd0, 8'd0, 1'b1, 3'd0));
    send_item(make_item(ACT_DRAW, 8'd255, 8'd255, 8'd0, 8'd0, 1'b1, 3'd0));
    send_item(make_item(ACT_TOGGLE, 8'd0, 8'd64, 8'd0, 8'd0, 1'b0, 3'd0));
    send_item(make_item(ACT_READ_PIX, 8'd255, 8'd255, 8'd0, 8'd0, 1'b0, 3'd0));
    // toggle both ways
    send_item(make_item(ACT_TOGGLE, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 3'd0));
    send_item(make_item(ACT_TOGGLE, 8'd5, 8'd9, 8'd0, 8'd0, 1'b0, 3'd0));
    send_item(make_item(ACT_READ_BYTE, 8'd5, 8'd0, 8'd0, 8'd0, 1'b0, 3'd6));
    // rectangles: ends of 255 clamped, empty, start past the screen, full invert
    send_item(make_item(ACT_FILL, 8'd10, 8'd8, 8'd255, 8'd255, 1'b1, 3'd0));
    send_item(make_item(ACT_FILL, 8'd50, 8'd50, 8'd40, 8'd40, 1'b0, 3'd0));
    send_item(make_item(ACT_FILL, 8'd200, 8'd0, 8'd255, 8'd63, 1'b1, 3'd0));
    send_item(make_item(ACT_INVERT, 8'd0, 8'd0, 8'd255, 8'd255, 1'b0, 3'd0));
    send_item(make_item(ACT_READ_BYTE, 8'd10, 8'd0, 8'd0, 8'd0, 1'b0, 3'd6));
    send_item(make_item(ACT_FILL, 8'd3, 8'd3, 8'd4, 8'd12, 1'b0, 3'd0));
    // byte read past the last column, unused action code
    send_item(make_item(ACT_READ_BYTE, 8'd128, 8'd0, 8'd0, 8'd0, 1'b0, 3'd7));
    send_item(make_item(ACT_READ_BYTE, 8'd255, 8'd0, 8'd0, 8'd0, 1'b0, 3'd3));
    send_item(make_item(ACT_UNUSED, 8'd1, 8'd1, 8'd1, 8'd1, 1'b1, 3'd1));
    drain();
    send_item(make_item(ACT_CLEAR, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 3'd0));
    send_item(make_item(ACT_READ_BYTE, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 3'd7));

    // random actions, many aimed at recently drawn spots
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      item.pixel_x     = 8'($urandom_range(0, 255));
      item.pixel_y     = 8'($urandom_range(0, 255));
      item.x_end       = 8'($urandom_range(0, 255));
      item.y_end       = 8'($urandom_range(0, 255));
      item.pixel_value = 1'($urandom_range(0, 1));
      item.page_index  = 3'($urandom_range(0, 7));
      roll = $urandom_range(0, 99);
      if (roll < 22) item.action = ACT_DRAW;
      else if (roll < 40) item.action = ACT_READ_PIX;
      else if (roll < 50) item.action = ACT_TOGGLE;
      else if (roll < 60) item.action = ACT_FILL;
      else if (roll < 68) item.action = ACT_INVERT;
      else if (roll < 70) item.action = ACT_CLEAR;
      else if (roll < 97) item.action = ACT_READ_BYTE;
      else item.action = ACT_UNUSED;

      // coordinates: recent spot, on screen, or anywhere
      roll = $urandom_range(0, 99);
      if (roll < 40 && spot_x.size() > 0) begin
        pick = $urandom_range(0, spot_x.size() - 1);
        item.pixel_x = spot_x[pick];
        item.pixel_y = spot_y[pick];
      end else if (roll < 92) begin
        item.pixel_x = 8'($urandom_range(0, 127));
        item.pixel_y = 8'($urandom_range(0, 63));
      end

      // rectangles are mostly small, a few span the screen
      if (item.action == ACT_FILL || item.action == ACT_INVERT) begin
        roll = $urandom_range(0, 99);
        if (roll < 92) begin
          item.x_end = item.pixel_x + 8'($urandom_range(0, 7));
          item.y_end = item.pixel_y + 8'($urandom_range(0, 15));
        end else if (roll >= 97) begin
          item.pixel_x = 8'($urandom_range(0, 7));
          item.pixel_y = 8'($urandom_range(0, 7));
          item.x_end   = 8'($urandom_range(120, 255));
          item.y_end   = 8'($urandom_range(56, 255));
        end
      end

      // byte reads mostly land on the page holding the chosen row
      if (item.action == ACT_READ_BYTE && item.pixel_y < 8'd64 && $urandom_range(0, 99) < 60) begin
        item.page_index = 3'd7 - item.pixel_y[5:3];
      end

      if ((item.action == ACT_DRAW || item.action == ACT_TOGGLE || item.action == ACT_FILL)
          && item.pixel_x < 8'd128 && item.pixel_y < 8'd64) begin
        spot_x.push_back(item.pixel_x);
        spot_y.push_back(item.pixel_y);
        if (spot_x.size() > 16) begin
          void'(spot_x.pop_front());
          void'(spot_y.pop_front());
        end
      end

      send_item(item);
      if (item.action != ACT_UNUSED) sent++;
      if ($urandom_range(0, 99) == 0) drain();
    end

    // wind down
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("tb_mono_page_framebuffer_engine: clean");
    end else begin
      $display("tb_mono_page_framebuffer_engine: errors");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/mpfe_pkg.sv
rtl/mpfe_ctrl.sv
rtl/mpfe_datapath.sv
rtl/mono_page_framebuffer_engine.sv
rtl/mpfe_checker.sv
tb/sv/mpfe_frame_checker.sv
tb/sv/tb_mono_page_framebuffer_engine.sv
